// ===== src/mkaw_pkg.sv =====
// Shared types, widths, register codes and the acceleration curve for the
// mouse-key acceleration and warp block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mkaw_pkg;

    localparam int FRAC_BITS         = 8;
    localparam int ACC_W             = FRAC_BITS + 4;
    localparam int ACCEL_TABLE_DEPTH = 256;
    localparam int IDX_W             = $clog2(ACCEL_TABLE_DEPTH);
    localparam int CLIMB_MILLI       = 50;
    localparam int RUNWAY_MILLI      = 4000;
    localparam int MULT_MILLI        = 5000;

    localparam int STEP_W   = 8;
    localparam int CNT_W    = 8;
    localparam int COORD_W  = 15;
    localparam int FLOOR_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int PROD_W   = STEP_W + ACC_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WARP_FULL_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARP_FULL_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_FLOOR      = 2'd2;

    localparam logic [COORD_W-1:0] WARP_FULL_RESET   = 15'd32767;
    localparam logic [FLOOR_W-1:0] ACCEL_FLOOR_RESET = 12'd64;

    localparam logic KIND_REL = 1'b0;
    localparam logic KIND_ABS = 1'b1;
    localparam logic MODE_MOVE = 1'b0;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam int CORDIC_STEPS = 28;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ROM_DEN = 64'sd1000 <<< 30;
    localparam longint ATAN_Q30 [CORDIC_STEPS] = '{
        843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388438, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8
    };

    typedef struct packed {
        logic                       kind;
        logic signed [STEP_W-1:0]   rel_x;
        logic signed [STEP_W-1:0]   rel_y;
        logic        [COORD_W-1:0]  abs_x;
        logic        [COORD_W-1:0]  abs_y;
    } t_result;

    typedef struct packed {
        logic signed [STEP_W-1:0]    rel;
        logic        [FRAC_BITS-1:0] carry;
    } t_lane_out;

    // Curve entry k: (atan(k*climb - runway) + pi/2) * mult, 4.FRAC_BITS format.
    // Evaluated at elaboration only.
    function automatic logic [ACC_W-1:0] rom_entry(input int k);
        longint x;
        longint y;
        longint z;
        longint n;
        longint v;
        longint dx;
        longint dy;
        longint num;
        longint e;
        int     i;
        n = longint'(k) * longint'(CLIMB_MILLI) - longint'(RUNWAY_MILLI);
        x = longint'(1000) <<< 20;
        y = n <<< 20;
        z = 0;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_Q30[i];
            end else if (y < 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_Q30[i];
            end
        end
        v = z + HALF_PI_Q30;
        if (v < 0) begin
            v = 0;
        end
        num = (v * longint'(MULT_MILLI)) <<< FRAC_BITS;
        e = (num + ROM_DEN / 2) / ROM_DEN;
        if (e > longint'(ACC_MAX)) begin
            return ACC_MAX;
        end
        return ACC_W'(e);
    endfunction

endpackage

`default_nettype wire

// ===== src/mkaw_accel.sv =====
// Acceleration factor lookup: constant arctangent table indexed by the active
// count, floored by the programmed minimum. Uses mkaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkaw_accel (
    input  wire logic [mkaw_pkg::CNT_W-1:0]   i_count,
    input  wire logic [mkaw_pkg::FLOOR_W-1:0] i_floor,
    output logic      [mkaw_pkg::ACC_W-1:0]   o_factor
);

    logic [mkaw_pkg::ACC_W-1:0] rom [mkaw_pkg::ACCEL_TABLE_DEPTH];
    logic [mkaw_pkg::IDX_W-1:0] idx;
    logic [mkaw_pkg::ACC_W-1:0] entry;

    for (genvar k = 0; k < mkaw_pkg::ACCEL_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [mkaw_pkg::ACC_W-1:0] ENTRY_K = mkaw_pkg::rom_entry(k);
        assign rom[k] = ENTRY_K;
    end

    always_comb begin
        // clamp the count to the last table row
        if (32'(i_count) < 32'(mkaw_pkg::ACCEL_TABLE_DEPTH)) begin
            idx = mkaw_pkg::IDX_W'(i_count);
        end else begin
            idx = mkaw_pkg::IDX_W'(mkaw_pkg::ACCEL_TABLE_DEPTH - 1);
        end
        entry = rom[idx];
        if (32'(entry) < 32'(i_floor)) begin
            o_factor = mkaw_pkg::ACC_W'(i_floor);
        end else begin
            o_factor = entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/mkaw_lane.sv =====
// One axis lane: magnitude times factor plus fractional carry, split into a
// saturated signed motion and a new carry. Uses mkaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkaw_lane (
    input  wire logic signed [mkaw_pkg::STEP_W-1:0]    i_step,
    input  wire logic        [mkaw_pkg::ACC_W-1:0]     i_factor,
    input  wire logic        [mkaw_pkg::FRAC_BITS-1:0] i_carry,
    output mkaw_pkg::t_lane_out                        o_lane
);

    localparam int WHOLE_W = mkaw_pkg::PROD_W - mkaw_pkg::FRAC_BITS;

    logic                          neg;
    logic [mkaw_pkg::STEP_W-1:0]   mag;
    logic [mkaw_pkg::PROD_W-1:0]   m;
    logic [WHOLE_W-1:0]            whole;
    logic [mkaw_pkg::STEP_W-2:0]   sat;

    always_comb begin
        neg   = i_step[mkaw_pkg::STEP_W-1];
        mag   = neg ? (~i_step + 1'b1) : i_step;
        m     = mkaw_pkg::PROD_W'(mag) * mkaw_pkg::PROD_W'(i_factor)
              + mkaw_pkg::PROD_W'(i_carry);
        whole = m[mkaw_pkg::PROD_W-1:mkaw_pkg::FRAC_BITS];
        sat   = (whole > WHOLE_W'({(mkaw_pkg::STEP_W-1){1'b1}}))
              ? {(mkaw_pkg::STEP_W-1){1'b1}} : whole[mkaw_pkg::STEP_W-2:0];
        if (i_step == '0) begin
            // idle axis: no motion, carry kept
            o_lane.rel   = '0;
            o_lane.carry = i_carry;
        end else begin
            o_lane.rel   = neg ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
            o_lane.carry = m[mkaw_pkg::FRAC_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/mouse_key_accel_and_warp_top.sv =====
// Top level of the mouse-key acceleration and warp block: state, config
// registers, warp region logic, two axis lanes and a skid output stage.
// Uses mkaw_pkg, mkaw_accel and mkaw_lane.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall    | mode, move_x/y, warp_* bits
//  out     | output    | o_out_valid / i_out_stall  | kind, rel_x/y, abs_x/y
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One item per cycle while the input is not stalled; an item that has a result has it
// registered, together with the carry update from the combinational lane multiply-add.
// A skid register takes one result while the output is stalled; the input
// stalls only while that skid register is occupied.
// Reset is synchronous, active low, clears the control state and loads the config defaults.
`timescale 1ns / 1ps
`default_nettype none

module mouse_key_accel_and_warp_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mkaw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mkaw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_mode,
    input  wire logic signed [mkaw_pkg::STEP_W-1:0]  i_move_x,
    input  wire logic signed [mkaw_pkg::STEP_W-1:0]  i_move_y,
    input  wire logic                                i_warp_up,
    input  wire logic                                i_warp_down,
    input  wire logic                                i_warp_left,
    input  wire logic                                i_warp_right,
    input  wire logic                                i_warp_end,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_kind,
    output logic signed [mkaw_pkg::STEP_W-1:0]       o_rel_x,
    output logic signed [mkaw_pkg::STEP_W-1:0]       o_rel_y,
    output logic        [mkaw_pkg::COORD_W-1:0]      o_abs_x,
    output logic        [mkaw_pkg::COORD_W-1:0]      o_abs_y
);

    localparam int CW = mkaw_pkg::COORD_W;

    logic [CW-1:0]                      r_full_w, r_full_h;
    logic [mkaw_pkg::FLOOR_W-1:0]       r_floor;
    logic [mkaw_pkg::CNT_W-1:0]         r_count, n_count;
    logic [mkaw_pkg::FRAC_BITS-1:0]     r_carry_x, n_carry_x, r_carry_y, n_carry_y;
    logic                               r_warping, n_warping;
    logic [CW-1:0]                      r_left, n_left, r_top, n_top;
    logic [CW-1:0]                      r_width, n_width, r_height, n_height;
    mkaw_pkg::t_result                  r_out, r_skid, res;
    logic                               r_out_valid, r_skid_valid;

    logic                               in_acc, out_take, has_res, zero_move;
    logic [mkaw_pkg::ACC_W-1:0]         factor;
    mkaw_pkg::t_lane_out                lane_x, lane_y;
    logic [CW-1:0]                      base_l, base_t, base_w, base_h;

    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign zero_move  = (i_move_x == '0) && (i_move_y == '0);

    assign n_count = (r_count == {mkaw_pkg::CNT_W{1'b1}}) ? r_count : r_count + 1'b1;

    mkaw_accel u_accel (
        .i_count  (n_count),
        .i_floor  (r_floor),
        .o_factor (factor)
    );

    mkaw_lane u_lane_x (
        .i_step   (i_move_x),
        .i_factor (factor),
        .i_carry  (r_carry_x),
        .o_lane   (lane_x)
    );

    mkaw_lane u_lane_y (
        .i_step   (i_move_y),
        .i_factor (factor),
        .i_carry  (r_carry_y),
        .o_lane   (lane_y)
    );

    // merge the lanes or the warp region into one result beat
    always_comb begin
        base_l = r_warping ? r_left   : '0;
        base_t = r_warping ? r_top    : '0;
        base_w = r_warping ? r_width  : r_full_w;
        base_h = r_warping ? r_height : r_full_h;

        n_carry_x = r_carry_x;
        n_carry_y = r_carry_y;
        n_warping = r_warping;
        n_left    = r_left;
        n_top     = r_top;
        n_width   = r_width;
        n_height  = r_height;
        has_res   = 1'b0;
        res       = '0;

        if (i_mode == mkaw_pkg::MODE_MOVE) begin
            if (!zero_move) begin
                n_carry_x = lane_x.carry;
                n_carry_y = lane_y.carry;
                n_warping = 1'b0;
                has_res   = 1'b1;
                res.kind  = mkaw_pkg::KIND_REL;
                res.rel_x = lane_x.rel;
                res.rel_y = lane_y.rel;
            end
        end else begin
            n_left   = base_l;
            n_top    = base_t;
            n_width  = base_w;
            n_height = base_h;
            if (i_warp_end) begin
                n_warping = 1'b0;
            end else begin
                n_warping = 1'b1;
                n_width   = base_w >> 1;
                n_height  = base_h >> 1;
                if (!i_warp_up && i_warp_down) begin
                    n_top = base_t + n_height;
                end
                if (!i_warp_left && i_warp_right) begin
                    n_left = base_l + n_width;
                end
                has_res   = 1'b1;
                res.kind  = mkaw_pkg::KIND_ABS;
                res.abs_x = n_left + (n_width >> 1);
                res.abs_y = n_top + (n_height >> 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_w <= mkaw_pkg::WARP_FULL_RESET;
            r_full_h <= mkaw_pkg::WARP_FULL_RESET;
            r_floor  <= mkaw_pkg::ACCEL_FLOOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mkaw_pkg::CFG_WARP_FULL_WIDTH:  r_full_w <= i_cfg_data;
                mkaw_pkg::CFG_WARP_FULL_HEIGHT: r_full_h <= i_cfg_data;
                mkaw_pkg::CFG_ACCEL_FLOOR:      r_floor  <= i_cfg_data[mkaw_pkg::FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_carry_x <= '0;
            r_carry_y <= '0;
            r_warping <= 1'b0;
            r_left    <= '0;
            r_top     <= '0;
            r_width   <= '0;
            r_height  <= '0;
        end else if (in_acc) begin
            if (i_mode == mkaw_pkg::MODE_MOVE) begin
                r_count <= zero_move ? '0 : n_count;
            end
            r_carry_x <= n_carry_x;
            r_carry_y <= n_carry_y;
            r_warping <= n_warping;
            r_left    <= n_left;
            r_top     <= n_top;
            r_width   <= n_width;
            r_height  <= n_height;
        end
    end

    // output register with one skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc && has_res;
            end
        end else if (in_acc && has_res) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_acc && has_res) begin
            r_skid <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out.kind;
    assign o_rel_x     = r_out.rel_x;
    assign o_rel_y     = r_out.rel_y;
    assign o_abs_x     = r_out.abs_x;
    assign o_abs_y     = r_out.abs_y;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a beat while the output register is empty");

    a_rel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == mkaw_pkg::KIND_REL) |->
            (o_rel_x != -8'sd128 && o_rel_y != -8'sd128 && o_abs_x == '0 && o_abs_y == '0))
        else $error("relative report out of range or carries coordinates");

    a_abs_no_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == mkaw_pkg::KIND_ABS) |-> (o_rel_x == '0 && o_rel_y == '0))
        else $error("absolute report carries relative motion");

    a_zero_move_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == mkaw_pkg::MODE_MOVE && zero_move) |=> (r_count == '0))
        else $error("zero move did not clear the active count");

endmodule

`default_nettype wire

// ===== test/mouse_key_accel_and_warp_top_test.sv =====
// Self-checking testbench for mouse_key_accel_and_warp_top: accelerated relative
// moves with subpixel carry and region-halving warps, checked beat by beat.
// Depends on mkaw_pkg and the top level; an internal predictor rebuilds the curve.
`timescale 1ns / 1ps

module mouse_key_accel_and_warp_top_test;

    localparam logic MODE_WARP = ~mkaw_pkg::MODE_MOVE;
    localparam int   FRAC = 8;
    localparam int   FACTOR_W = 12;
    localparam longint CURVE_DEN = longint'(1000) * (longint'(1) << 30);
    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
    localparam longint ARCTAN_Q30 [28] = '{
        843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388438, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8
    };

    typedef struct packed {
        logic              mode;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic              up;
        logic              down;
        logic              left;
        logic              right;
        logic              stop;
    } t_key_event;

    localparam int EV_W = $bits(t_key_event);

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [mkaw_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [mkaw_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_mode;
    logic signed [mkaw_pkg::STEP_W-1:0] i_move_x;
    logic signed [mkaw_pkg::STEP_W-1:0] i_move_y;
    logic                   i_warp_up;
    logic                   i_warp_down;
    logic                   i_warp_left;
    logic                   i_warp_right;
    logic                   i_warp_end;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_kind;
    logic signed [mkaw_pkg::STEP_W-1:0] o_rel_x;
    logic signed [mkaw_pkg::STEP_W-1:0] o_rel_y;
    logic [mkaw_pkg::COORD_W-1:0]     o_abs_x;
    logic [mkaw_pkg::COORD_W-1:0]     o_abs_y;

    mouse_key_accel_and_warp_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_move_x     (i_move_x),
        .i_move_y     (i_move_y),
        .i_warp_up    (i_warp_up),
        .i_warp_down  (i_warp_down),
        .i_warp_left  (i_warp_left),
        .i_warp_right (i_warp_right),
        .i_warp_end   (i_warp_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_rel_x      (o_rel_x),
        .o_rel_y      (o_rel_y),
        .o_abs_x      (o_abs_x),
        .o_abs_y      (o_abs_y)
    );

    // Stimulus and expectation stores
    t_key_event          pending_events[$];
    mkaw_pkg::t_result   expected_reports[$];
    int          n_queued;
    int          n_taken;
    int          mismatches;
    bit          in_beat;
    int          hold_off;
    int          stall_left;
    bit          idle_on;

    // Predictor state
    logic [FACTOR_W-1:0] accel_curve[256];
    logic [7:0]          run_len;
    logic [FRAC-1:0]     frac_x;
    logic [FRAC-1:0]     frac_y;
    logic                warp_on;
    logic [mkaw_pkg::COORD_W-1:0]  reg_left;
    logic [mkaw_pkg::COORD_W-1:0]  reg_top;
    logic [mkaw_pkg::COORD_W-1:0]  reg_w;
    logic [mkaw_pkg::COORD_W-1:0]  reg_h;
    logic [mkaw_pkg::COORD_W-1:0]  cfg_w;
    logic [mkaw_pkg::COORD_W-1:0]  cfg_h;
    logic [FACTOR_W-1:0] cfg_floor;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Arctangent curve entry k by vectoring CORDIC, 4.8 fixed point.
    function automatic logic [FACTOR_W-1:0] curve_point(input int k);
        longint cx;
        longint cy;
        longint ang;
        longint sx;
        longint sy;
        longint v;
        longint e;
        cx = longint'(1000) * 1048576;
        cy = (longint'(k) * 50 - 4000) * 1048576;
        ang = 0;
        for (int i = 0; i < 28; i++) begin
            sx = cy >>> i;
            sy = cx >>> i;
            if (cy > 0) begin
                cx = cx + sx;
                cy = cy - sy;
                ang = ang + ARCTAN_Q30[i];
            end else if (cy < 0) begin
                cx = cx - sx;
                cy = cy + sy;
                ang = ang - ARCTAN_Q30[i];
            end
        end
        v = ang + QUARTER_TURN_Q30;
        if (v < 0) v = 0;
        e = (v * 5000 * 256 + CURVE_DEN / 2) / CURVE_DEN;
        if (e > 4095) e = 4095;
        return e[FACTOR_W-1:0];
    endfunction

    task automatic scale_axis(input logic signed [7:0] step, input logic [FACTOR_W-1:0] factor,
                              inout logic [FRAC-1:0] frac, output logic signed [7:0] rel);
        logic [7:0]  mag;
        logic [19:0] acc;
        logic [19:0] whole;
        if (step == 0) begin
            rel = 0;
        end else begin
            mag = step[7] ? (~step + 8'd1) : step;
            acc = 20'(mag) * 20'(factor) + 20'(frac);
            frac = acc[FRAC-1:0];
            whole = acc >> FRAC;
            if (whole > 20'd127) whole = 20'd127;
            rel = step[7] ? -$signed(whole[7:0]) : $signed(whole[7:0]);
        end
    endtask

    task automatic predict_event(input t_key_event ev);
        mkaw_pkg::t_result   r;
        logic [FACTOR_W-1:0] factor;
        r = '0;
        if (ev.mode == mkaw_pkg::MODE_MOVE) begin
            if (ev.dx == 0 && ev.dy == 0) begin
                run_len = 0;
                return;
            end
            if (run_len != 8'd255) run_len = run_len + 8'd1;
            factor = accel_curve[run_len];
            if (factor < cfg_floor) factor = cfg_floor;
            scale_axis(ev.dx, factor, frac_x, r.rel_x);
            scale_axis(ev.dy, factor, frac_y, r.rel_y);
            r.kind = mkaw_pkg::KIND_REL;
            warp_on = 1'b0;
            expected_reports.push_back(r);
        end else begin
            if (!warp_on) begin
                reg_left = 0;
                reg_top = 0;
                reg_w = cfg_w;
                reg_h = cfg_h;
                warp_on = 1'b1;
            end
            if (ev.stop) begin
                warp_on = 1'b0;
                return;
            end
            reg_w = reg_w >> 1;
            reg_h = reg_h >> 1;
            if (!ev.up && ev.down) reg_top = reg_top + reg_h;
            if (!ev.left && ev.right) reg_left = reg_left + reg_w;
            r.kind = mkaw_pkg::KIND_ABS;
            r.abs_x = reg_left + (reg_w >> 1);
            r.abs_y = reg_top + (reg_h >> 1);
            expected_reports.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        mismatches++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    task automatic check_report();
        mkaw_pkg::t_result want;
        if (expected_reports.size() == 0) begin
            mismatches++;
            $error("unexpected result beat, kind %0d", o_kind);
            return;
        end
        want = expected_reports.pop_front();
        if (o_kind !== want.kind) report_mismatch("kind", want.kind, o_kind);
        if (o_rel_x !== want.rel_x) report_mismatch("rel_x", want.rel_x, o_rel_x);
        if (o_rel_y !== want.rel_y) report_mismatch("rel_y", want.rel_y, o_rel_y);
        if (o_abs_x !== want.abs_x) report_mismatch("abs_x", want.abs_x, o_abs_x);
        if (o_abs_y !== want.abs_y) report_mismatch("abs_y", want.abs_y, o_abs_y);
    endtask

    // Monitor: sample both channels at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_beat = 1'b0;
        end else begin
            in_beat = i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) check_report();
            if (in_beat) begin
                n_taken++;
                predict_event({i_mode, i_move_x, i_move_y, i_warp_up, i_warp_down,
                               i_warp_left, i_warp_right, i_warp_end});
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Driver: advance to the next beat only after the current one is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat) begin
            if (hold_off > 0) begin
                hold_off--;
                i_in_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                {i_mode, i_move_x, i_move_y, i_warp_up, i_warp_down,
                 i_warp_left, i_warp_right, i_warp_end} <= pending_events.pop_front();
                i_in_valid <= 1'b1;
                hold_off = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(negedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                i_out_stall <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else if (r < 90) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(9, 39);
            end
        end
    end

    task automatic push_event(input t_key_event ev);
        pending_events.push_back(ev);
        n_queued++;
    endtask

    task automatic push_move(input logic signed [7:0] x, input logic signed [7:0] y);
        t_key_event ev;
        ev = t_key_event'(EV_W'($urandom));
        ev.mode = mkaw_pkg::MODE_MOVE;
        ev.dx = x;
        ev.dy = y;
        push_event(ev);
    endtask

    task automatic push_warp(input logic u, input logic d, input logic l, input logic r,
                             input logic s);
        t_key_event ev;
        ev.dx = 8'($urandom);
        ev.dy = 8'($urandom);
        ev.mode = MODE_WARP;
        ev.up = u;
        ev.down = d;
        ev.left = l;
        ev.right = r;
        ev.stop = s;
        push_event(ev);
    endtask

    function automatic logic signed [7:0] rand_step();
        int r;
        logic signed [7:0] s;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r < 3) return 8'($urandom);
        s = 8'($urandom_range(1, 6));
        return $urandom_range(0, 1) ? -s : s;
    endfunction

    // Mostly well-formed move runs and warp descents; the rest is noise.
    task automatic queue_random(input int n_items);
        int made;
        int r;
        int len;
        made = 0;
        while (made < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                len = $urandom_range(1, 20);
                repeat (len) push_move(rand_step(), rand_step());
                made += len;
            end else if (r < 85) begin
                len = $urandom_range(1, 16);
                repeat (len) push_warp(1'($urandom), 1'($urandom), 1'($urandom),
                                       1'($urandom), 1'b0);
                made += len;
                if ($urandom_range(0, 1)) begin
                    push_warp(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'b1);
                    made++;
                end
            end else if (r < 93) begin
                push_move(0, 0);
                made++;
            end else begin
                push_event(t_key_event'(EV_W'($urandom)));
                made++;
            end
        end
    endtask

    // Wait until every beat is taken and every result has come back.
    task automatic drain();
        do @(negedge i_clk);
        while (n_taken != n_queued || expected_reports.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mkaw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mkaw_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            mkaw_pkg::CFG_WARP_FULL_WIDTH: cfg_w = data[mkaw_pkg::COORD_W-1:0];
            mkaw_pkg::CFG_WARP_FULL_HEIGHT: cfg_h = data[mkaw_pkg::COORD_W-1:0];
            mkaw_pkg::CFG_ACCEL_FLOOR: cfg_floor = data[FACTOR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [14:0] w, input logic [14:0] h, input logic [14:0] fl);
        drain();
        write_reg(mkaw_pkg::CFG_WARP_FULL_WIDTH, w);
        write_reg(mkaw_pkg::CFG_WARP_FULL_HEIGHT, h);
        write_reg(mkaw_pkg::CFG_ACCEL_FLOOR, fl);
        idle_on = $urandom_range(0, 3) != 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = mkaw_pkg::MODE_MOVE;
        i_move_x = '0;
        i_move_y = '0;
        i_warp_up = 1'b0;
        i_warp_down = 1'b0;
        i_warp_left = 1'b0;
        i_warp_right = 1'b0;
        i_warp_end = 1'b0;
        i_out_stall = 1'b0;
        n_queued = 0;
        n_taken = 0;
        mismatches = 0;
        in_beat = 1'b0;
        hold_off = 0;
        stall_left = 0;
        idle_on = 1'b1;
        for (int k = 0; k < 256; k++) accel_curve[k] = curve_point(k);
        run_len = 0;
        frac_x = 0;
        frac_y = 0;
        warp_on = 1'b0;
        reg_left = 0;
        reg_top = 0;
        reg_w = 0;
        reg_h = 0;
        cfg_w = mkaw_pkg::WARP_FULL_RESET;
        cfg_h = mkaw_pkg::WARP_FULL_RESET;
        cfg_floor = mkaw_pkg::ACCEL_FLOOR_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: step extremes, single-axis moves, zero move, warp corners and end.
        push_move(127, -128);
        push_move(-128, 127);
        push_move(0, 1);
        push_move(-1, 0);
        push_move(0, 0);
        push_move(1, 1);
        push_move(-128, -128);
        push_move(127, 127);
        push_warp(1, 1, 1, 1, 0);
        push_warp(0, 1, 0, 1, 0);
        push_warp(1, 0, 1, 0, 0);
        push_move(0, 0);
        push_warp(0, 1, 0, 1, 0);
        push_warp(0, 0, 0, 0, 1);
        push_warp(1, 1, 1, 1, 1);
        push_warp(0, 1, 1, 0, 0);
        push_move(3, -3);
        push_warp(0, 0, 0, 0, 0);
        push_warp(1, 0, 0, 1, 0);
        push_move(0, 0);
        push_move(5, 0);
        queue_random(180);

        configure(15'd1, 15'd1, 15'd0);
        push_warp(0, 1, 0, 1, 0);
        push_warp(0, 1, 0, 1, 0);
        queue_random(200);

        // Drive the run counter into saturation with small steps, no idling.
        configure(15'd32767, 15'd32767, 15'h7FFF);
        idle_on = 1'b0;
        repeat (270) push_move($urandom_range(0, 1) ? 8'sd1 : -8'sd2,
                               8'($urandom_range(0, 3)));
        queue_random(60);

        configure(15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)),
                  15'($urandom_range(0, 4095)));
        queue_random(200);

        configure(15'd32767, 15'd1, 15'd2000);
        queue_random(200);

        configure(15'd2, 15'd32767, 15'd1000);
        queue_random(160);

        drain();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
